>>> hw/rtl/ddo_pkg.sv
// ---------------------------------------------------------------------------
// ddo_pkg
// Shared types, CORDIC angle table and constants for the odometry unit.
// ---------------------------------------------------------------------------
package ddo_pkg;

    localparam int CordicMax = 24;
    localparam logic signed [63:0] CordicGainInv = 64'sd652032874;
    localparam logic [31:0] InvTwoPiQ32 = 32'd683565276;

    localparam logic [3:0] REG_AXLE_LENGTH = 4'd0;
    localparam logic [3:0] REG_TIME_STEP   = 4'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_TRIG0,
        S_PHI_DIV,
        S_TRIG1,
        S_MUL,
        S_DIV_X,
        S_DIV_Y,
        S_UPDATE,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the input item
        logic trig_start; // start CORDIC on current heading
        logic trig_new;   // start CORDIC on new heading
        logic div_start;  // start divider
        logic [1:0] div_sel; // 0 phi, 1 dx, 2 dy
        logic mul;        // compute move numerators
        logic shift;      // round straight moves by 2^22
        logic update;     // write pose
    } t_cmd;

    // Status back to the controller.
    typedef struct packed {
        logic trig_done;
        logic div_done;
        logic straight;
    } t_status;

    localparam logic [1:0] DIV_PHI = 2'd0;
    localparam logic [1:0] DIV_DX  = 2'd1;
    localparam logic [1:0] DIV_DY  = 2'd2;

    function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
        logic signed [31:0] r;
        begin
            r = 32'sd0;
            case (i)
                5'd0: r = 32'h20000000;
                5'd1: r = 32'h12E4051E;
                5'd2: r = 32'h09FB385B;
                5'd3: r = 32'h051111D4;
                5'd4: r = 32'h028B0D43;
                5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E;
                5'd7: r = 32'h00517C55;
                5'd8: r = 32'h0028BE53;
                5'd9: r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2F9;
                5'd15: r = 32'h0000517C;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A2F;
                5'd19: r = 32'h00000517;
                5'd20: r = 32'h0000028B;
                5'd21: r = 32'h00000145;
                5'd22: r = 32'h000000A2;
                5'd23: r = 32'h00000051;
                default: r = 32'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> hw/rtl/differential_drive_odometry_unit.sv
// Straight moves use one CORDIC run; turning moves use two, on the start and new
// headings, each of TRIG_ITERATIONS steps limited to 24.
// Turning adds three divider runs: turn angle, then x and y moves.
// One item at a time: the next item is accepted only after the result is taken.
// Reset: synchronous active low; pose cleared, axle_length 25600, time_step 7093.
// ---------------------------------------------------------------------------
// differential_drive_odometry_unit
// Fixed-point differential-drive odometry with CORDIC and serial divider.
// ---------------------------------------------------------------------------
module differential_drive_odometry_unit
    import ddo_pkg::*;
#(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // left_speed[7:0], right_speed[15:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // pose_x[31:0], pose_y[63:32], pose_heading[79:64]
    output logic [1:0]  m_axis_tuser,  // went_straight[0], saturated[1]
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [15:0] r_axle, r_dt;
    t_cmd        w_cmd;
    t_status     w_status;
    logic [31:0] w_x, w_y;
    logic [15:0] w_h;
    logic        w_str, w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axle <= 16'd25600;
            r_dt   <= 16'd7093;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_AXLE_LENGTH: r_axle <= i_cfg_data;
                REG_TIME_STEP:   r_dt   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ddo_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(w_cmd), .i_status(w_status)
    );

    ddo_datapath #(.TrigIterations(TRIG_ITERATIONS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_left(s_axis_tdata[7:0]), .i_right(s_axis_tdata[15:8]),
        .i_axle(r_axle), .i_dt(r_dt),
        .o_x(w_x), .o_y(w_y), .o_heading(w_h), .o_straight(w_str), .o_sat(w_sat)
    );

    assign m_axis_tdata = {w_h, w_y, w_x};
    assign m_axis_tuser = {w_sat, w_str};
endmodule

>>> hw/rtl/ddo_cordic.sv
// ---------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC: 16-bit binary angle to cos/sin in Q2.30.
// ---------------------------------------------------------------------------
module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int Iterations = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [15:0]         i_angle,
    output logic                o_done,
    output logic signed [33:0]  o_cos,
    output logic signed [33:0]  o_sin
);
    localparam int Steps = (Iterations < CordicMax) ? Iterations : CordicMax;

    logic signed [33:0] r_x, r_y, n_x, n_y;
    logic signed [33:0] r_z, n_z;
    logic               r_flip, r_busy, r_done;
    logic [4:0]         r_i;
    logic [31:0]        w_a, w_af;
    logic               w_flip;
    logic signed [33:0] w_atan;

    assign w_a    = {i_angle, 16'd0};
    assign w_flip = (w_a + 32'h40000000) > 32'h80000000;
    assign w_af   = w_flip ? w_a + 32'h80000000 : w_a;
    assign w_atan = 34'(atan_turn(r_i));

    always_comb begin
        if (!r_z[33]) begin
            n_x = r_x - (r_y >>> r_i);
            n_y = r_y + (r_x >>> r_i);
            n_z = r_z - w_atan;
        end else begin
            n_x = r_x + (r_y >>> r_i);
            n_y = r_y - (r_x >>> r_i);
            n_z = r_z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= 34'(CordicGainInv);
                r_y    <= '0;
                r_z    <= 34'(signed'(w_af));
                r_flip <= w_flip;
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                if (32'(r_i) == Steps - 1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_i <= r_i + 5'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;
endmodule

>>> hw/rtl/ddo_divider.sv
// ---------------------------------------------------------------------------
// ddo_divider
// Radix-2 restoring divider with round half away from zero on signed numerator.
// ---------------------------------------------------------------------------
module ddo_divider
    import ddo_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [63:0]  i_num,
    input  logic [63:0]         i_den,
    output logic                o_done,
    output logic signed [63:0]  o_quot
);
    logic [63:0] r_rem, r_quo, r_den;
    logic        r_neg, r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [64:0] w_trial;
    logic [63:0] w_mag;

    assign w_mag   = i_num[63] ? 64'(-i_num) : 64'(i_num);
    assign w_trial = {r_rem, r_quo[63]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= w_mag + (i_den >> 1);
                r_den  <= i_den;
                r_neg  <= i_num[63];
            end else if (r_busy) begin
                if (!w_trial[64]) begin
                    r_rem <= w_trial[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[62:0], r_quo[63]};
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule

>>> hw/rtl/ddo_datapath.sv
// ---------------------------------------------------------------------------
// ddo_datapath
// Pose registers, operand staging, shared CORDIC and divider.
// ---------------------------------------------------------------------------
module ddo_datapath
    import ddo_pkg::*;
#(
    parameter int TrigIterations = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic signed [7:0]  i_left,
    input  logic signed [7:0]  i_right,
    input  logic [15:0]        i_axle,
    input  logic [15:0]        i_dt,
    output logic [31:0]        o_x,
    output logic [31:0]        o_y,
    output logic [15:0]        o_heading,
    output logic               o_straight,
    output logic               o_sat
);
    logic signed [8:0]  r_d;
    logic signed [31:0] r_px, r_py;
    logic [15:0]        r_h, r_h1;
    logic               r_straight, r_sat;
    logic signed [33:0] r_c0, r_s0;
    logic signed [63:0] r_nx, r_ny, r_dx, r_dy;
    logic signed [25:0] r_rnum, r_ddt;
    logic signed [24:0] r_vdt;
    logic [63:0]        r_den;
    logic [1:0]         r_div_sel;
    logic               r_busy_new;

    logic               w_tdone, w_ddone;
    logic signed [33:0] w_cos, w_sin;
    logic signed [63:0] w_num, w_q;
    logic [63:0]        w_dden;
    logic [16:0]        w_len;
    logic signed [64:0] w_sx, w_sy;
    logic signed [25:0] w_rn;
    logic [15:0]        w_angle;

    // round half away from zero of v / 2^22
    function automatic logic signed [63:0] round_q22(input logic signed [63:0] v);
        logic [63:0] mag, q;
        mag = v[63] ? 64'(-v) : 64'(v);
        q = (mag + (64'd1 << 21)) >> 22;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

    assign w_len = (i_axle == 16'd0) ? 17'd1 : {1'b0, i_axle};
    assign w_rn  = r_d[8] ? -r_rnum : r_rnum;
    // new heading is taken straight from the quotient as the phi divide ends
    assign w_angle = i_cmd.trig_new ? r_h + w_q[15:0] : r_h;

    ddo_cordic #(.Iterations(TrigIterations)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_cmd.trig_start | i_cmd.trig_new),
        .i_angle(w_angle),
        .o_done(w_tdone), .o_cos(w_cos), .o_sin(w_sin)
    );

    always_comb begin
        case (i_cmd.div_sel)
            DIV_PHI: begin
                w_num  = 64'(r_ddt) * 64'($signed({1'b0, InvTwoPiQ32}));
                w_dden = 64'(w_len) << 16;
            end
            DIV_DX: begin
                w_num  = r_nx;
                w_dden = r_den;
            end
            default: begin
                w_num  = r_ny;
                w_dden = r_den;
            end
        endcase
    end

    ddo_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(w_num), .i_den(w_dden), .o_done(w_ddone), .o_quot(w_q)
    );

    assign w_sx = 65'(r_px) + 65'(r_dx);
    assign w_sy = 65'(r_py) + 65'(r_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_h  <= '0;
            r_straight <= 1'b0;
            r_sat <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_d  <= 9'(i_right) - 9'(i_left);
                r_straight <= (i_right == i_left);
                r_h1 <= r_h;
                r_rnum <= 26'($signed(w_len)) * 26'(9'(i_right) + 9'(i_left));
                r_ddt <= 26'(9'(i_right) - 9'(i_left)) * 26'($signed({1'b0, i_dt}));
                r_vdt <= 25'(i_left) * 25'($signed({1'b0, i_dt}));
            end
            if (w_tdone && i_cmd.trig_new == 1'b0 && !r_busy_new) begin
                r_c0 <= w_cos;
                r_s0 <= w_sin;
            end
            if (i_cmd.div_start) r_div_sel <= i_cmd.div_sel;
            if (w_ddone) begin
                case (r_div_sel)
                    DIV_PHI: r_h1 <= r_h + w_q[15:0];
                    DIV_DX:  r_dx <= w_q;
                    default: r_dy <= w_q;
                endcase
            end
            // issued in the cycle the CORDIC result appears
            if (i_cmd.mul) begin
                if (r_straight) begin
                    r_nx <= 64'(r_vdt) * 64'(w_cos);
                    r_ny <= 64'(r_vdt) * 64'(w_sin);
                end else begin
                    r_nx <= (64'(w_rn) * (64'(w_sin) - 64'(r_s0))) <<< 7;
                    r_ny <= (64'(w_rn) * (64'(r_c0) - 64'(w_cos))) <<< 7;
                end
                r_den <= 64'(r_d[8] ? -r_d : r_d) << 30;
            end
            if (i_cmd.shift) begin
                r_dx <= round_q22(r_nx);
                r_dy <= round_q22(r_ny);
            end
            if (i_cmd.update) begin
                r_sat <= 1'b0;
                if (w_sx > 65'sh7FFFFFFF) begin
                    r_px <= 32'sh7FFFFFFF; r_sat <= 1'b1;
                end else if (w_sx < -65'sh80000000) begin
                    r_px <= 32'sh80000000; r_sat <= 1'b1;
                end else r_px <= w_sx[31:0];
                if (w_sy > 65'sh7FFFFFFF) begin
                    r_py <= 32'sh7FFFFFFF; r_sat <= 1'b1;
                end else if (w_sy < -65'sh80000000) begin
                    r_py <= 32'sh80000000; r_sat <= 1'b1;
                end else r_py <= w_sy[31:0];
                r_h <= r_h1;
            end
        end
    end

    // second CORDIC run must not overwrite the start-heading values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_busy_new <= 1'b0;
        else if (i_cmd.trig_new) r_busy_new <= 1'b1;
        else if (i_cmd.load) r_busy_new <= 1'b0;
    end

    assign o_status = '{trig_done: w_tdone, div_done: w_ddone, straight: r_straight};
    assign o_x = r_px;
    assign o_y = r_py;
    assign o_heading = r_h;
    assign o_straight = r_straight;
    assign o_sat = r_sat;
endmodule

>>> hw/rtl/ddo_ctrl.sv
// ---------------------------------------------------------------------------
// ddo_ctrl
// Sequencer for one odometry update and the output handshake.
// ---------------------------------------------------------------------------
module ddo_ctrl
    import ddo_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);
    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_SETUP;
            S_SETUP:   n_state = S_TRIG0;
            S_TRIG0:   if (i_status.trig_done)
                           n_state = i_status.straight ? S_MUL : S_PHI_DIV;
            S_PHI_DIV: if (i_status.div_done) n_state = S_TRIG1;
            S_TRIG1:   if (i_status.trig_done) n_state = S_MUL;
            S_MUL:     n_state = i_status.straight ? S_UPDATE : S_DIV_X;
            S_DIV_X:   if (i_status.div_done) n_state = S_DIV_Y;
            S_DIV_Y:   if (i_status.div_done) n_state = S_UPDATE;
            S_UPDATE:  n_state = S_OUT;
            S_OUT:     if (i_out_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // start pulses fire in the last cycle before the waiting state
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SETUP: o_cmd.trig_start = 1'b1;
            S_TRIG0: begin
                o_cmd.div_sel = DIV_PHI;
                if (i_status.trig_done) begin
                    o_cmd.mul = i_status.straight;
                    o_cmd.div_start = !i_status.straight;
                end
            end
            S_PHI_DIV: begin
                o_cmd.div_sel = DIV_PHI;
                o_cmd.trig_new = i_status.div_done;
            end
            S_TRIG1: o_cmd.mul = i_status.trig_done;
            S_MUL: begin
                o_cmd.shift = i_status.straight;
                o_cmd.div_start = !i_status.straight;
                o_cmd.div_sel = DIV_DX;
            end
            S_DIV_X: begin
                o_cmd.div_sel = DIV_DX;
                if (i_status.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel = DIV_DY;
                end
            end
            S_DIV_Y: o_cmd.div_sel = DIV_DY;
            S_UPDATE: o_cmd.update = 1'b1;
            S_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_SETUP) else $error("load outside idle");
`endif
endmodule

>>> sim/tb_differential_drive_odometry_unit.sv
// ---------------------------------------------------------------------------
// tb_differential_drive_odometry_unit
// Self-checking bench: drives wheel-speed items, predicts every pose in a
// bit-exact fixed-point model kept in the bench, and checks each output item
// in order, with random source gaps and sink stalls outside the no-gap test.
// ---------------------------------------------------------------------------
module tb_differential_drive_odometry_unit
    import ddo_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TRIG_STEPS = 16;
    localparam int SETTLE_CYCLES = 250;
    localparam longint GAIN_INV = 652032874;
    localparam longint INV_2PI_Q32 = 683565276;
    localparam longint ANGLE_TURNS [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] heading;
        logic        straight;
        logic        sat;
    } t_pose;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // left_speed[7:0], right_speed[15:8]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;        // pose_x[31:0], pose_y[63:32], heading[79:64]
    logic [1:0]  m_axis_tuser;        // went_straight[0], saturated[1]
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // bench copy of block state
    logic [15:0]        axle_q88 = 16'd25600;
    logic [15:0]        step_q88 = 16'd7093;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic [15:0]        heading = '0;

    t_pose pending_poses[$];
    int    mismatch_count = 0;
    bit    gaps_on = 1'b1;
    int    sink_hold = 0;

    differential_drive_odometry_unit #(.TRIG_ITERATIONS(TRIG_STEPS)) DUT (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic longint round_div(input longint num, input longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // binary angle -> cos, sin in Q2.30 via CORDIC, half-plane folded
    function automatic void angle_cos_sin(input logic [15:0] h, output longint c,
                                          output longint s);
        logic [31:0] a;
        bit flip;
        longint x, y, z, xs, ys;
        a = {h, 16'h0000};
        flip = 1'b0;
        x = GAIN_INV;
        y = 0;
        if (32'(a + 32'h40000000) > 32'h80000000) begin
            a = a + 32'h80000000;
            flip = 1'b1;
        end
        z = longint'($signed(a));
        for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ANGLE_TURNS[i];
            end else begin
                x += ys; y -= xs; z += ANGLE_TURNS[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic signed [31:0] clamp_pos(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_pose advance_pose(input logic signed [7:0] left,
                                           input logic signed [7:0] right);
        longint vl, vr, dif, sum, len, dt, c0, s0, c1, s1, dx, dy, phi, rnum, den;
        logic [15:0] h1;
        t_pose p;
        vl = left;
        vr = right;
        dif = vr - vl;
        sum = vr + vl;
        len = (axle_q88 == 0) ? 1 : longint'(axle_q88);
        dt = longint'(step_q88);
        h1 = heading;
        p.sat = 1'b0;
        p.straight = (dif == 0);
        angle_cos_sin(heading, c0, s0);
        if (p.straight) begin
            dx = round_div(vl * dt * c0, 64'sd1 << 22);
            dy = round_div(vl * dt * s0, 64'sd1 << 22);
        end else begin
            phi = round_div(dif * dt * INV_2PI_Q32, len * 65536);
            h1 = 16'(longint'(heading) + phi);
            angle_cos_sin(h1, c1, s1);
            rnum = len * sum * 128;
            if (dif < 0) rnum = -rnum;
            den = ((dif < 0) ? -dif : dif) <<< 30;
            dx = round_div(rnum * (s1 - s0), den);
            dy = round_div(rnum * (c0 - c1), den);
        end
        pos_x = clamp_pos(longint'(pos_x) + dx, p.sat);
        pos_y = clamp_pos(longint'(pos_y) + dy, p.sat);
        heading = h1;
        p.x = pos_x;
        p.y = pos_y;
        p.heading = h1;
        return p;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %h expected %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // sink: random stalls, plus long hold-offs counted here
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !gaps_on || ($urandom_range(99) >= 28);
        end
    end

    always @(posedge i_clk) begin
        t_pose want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_poses.size() == 0) begin
                report_mismatch("unexpected pose", m_axis_tdata[31:0], '0);
            end else begin
                want = pending_poses.pop_front();
                if (m_axis_tdata[31:0] !== want.x)
                    report_mismatch("pose_x", m_axis_tdata[31:0], want.x);
                if (m_axis_tdata[63:32] !== want.y)
                    report_mismatch("pose_y", m_axis_tdata[63:32], want.y);
                if (m_axis_tdata[79:64] !== want.heading)
                    report_mismatch("heading", 32'(m_axis_tdata[79:64]),
                                    32'(want.heading));
                if (m_axis_tuser[0] !== want.straight)
                    report_mismatch("went_straight", 32'(m_axis_tuser[0]),
                                    32'(want.straight));
                if (m_axis_tuser[1] !== want.sat)
                    report_mismatch("saturated", 32'(m_axis_tuser[1]), 32'(want.sat));
            end
        end
    end

    // tvalid is left high after acceptance; the next call sets it once
    task automatic send_speeds(input logic [7:0] left, input logic [7:0] right);
        if (gaps_on && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {right, left};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_poses.push_back(advance_pose(left, right));
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [15:0] axle, input logic [15:0] dt);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_AXLE_LENGTH;
        i_cfg_data <= axle;
        @(posedge i_clk);
        i_cfg_index <= REG_TIME_STEP;
        i_cfg_data <= dt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        axle_q88 = axle;
        step_q88 = dt;
    endtask

    function automatic logic [7:0] rand_speed;
        case ($urandom_range(7))
            0: return 8'h80;
            1: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults;
        send_speeds(8'd10, 8'd20);
        send_speeds(8'h80, 8'h7F);
        send_speeds(8'h7F, 8'h80);
        send_speeds(8'd0, 8'd0);
        send_speeds(8'd1, 8'd0);
        send_speeds(8'hFF, 8'hFF);
    endtask

    task automatic test_extremes;
        set_geometry(16'd0, 16'd65535);     // zero axle reads as one
        send_speeds(8'h80, 8'h7F);
        send_speeds(8'h00, 8'h01);
        send_speeds(8'h7F, 8'h80);
        set_geometry(16'd65535, 16'd0);     // no motion at all
        send_speeds(8'h7F, 8'h80);
        send_speeds(8'h33, 8'h33);
        set_geometry(16'd1, 16'd65535);     // huge turn angles wrap heading
        send_speeds(8'd5, 8'd6);
        send_speeds(8'h80, 8'h80);
        send_speeds(8'h7F, 8'h7F);
    endtask

    task automatic test_saturation;
        set_geometry(16'd65535, 16'd65535);
        repeat (3) send_speeds(8'h7F, 8'h7F);
        repeat (5) send_speeds(8'h80, 8'h80);
        send_speeds(8'h80, 8'h7F);
        repeat (3) send_speeds(8'h7F, 8'h7F);
    endtask

    task automatic test_backpressure;
        sink_hold = 400;
        repeat (20) send_speeds(rand_speed(), rand_speed());
    endtask

    task automatic test_random(input int count);
        logic [7:0] l;
        for (int n = 0; n < count; n++) begin
            l = rand_speed();
            send_speeds(l, ($urandom_range(99) < 15) ? l : rand_speed());
        end
    endtask

    task automatic test_random_geometry;
        for (int p = 0; p < 6; p++) begin
            set_geometry(($urandom_range(3) == 0) ? 16'($urandom_range(0, 255))
                                                  : 16'($urandom),
                         16'($urandom));
            test_random(250);
        end
    endtask

    task automatic test_no_gaps;
        gaps_on = 1'b0;
        set_geometry(16'd25600, 16'd7093);
        test_random(300);
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_extremes();
        test_saturation();
        test_backpressure();
        test_random_geometry();
        test_no_gaps();
        drain();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
